[src/tcr_pkg.sv]
// ============================================================================
// tcr_pkg - shared types and constants for the tetrahedron circumradius unit
// Item layouts, state enums, scratch map and the micro-op program of the
// geometry engine.
// ============================================================================
package tcr_pkg;

    localparam int POINT_COUNT_DEF = 1024;
    localparam int COORD_BITS_DEF  = 16;
    localparam int SLOT_BITS       = 10;
    localparam int FIELD_BITS      = 16;
    localparam int RADIUS_BITS     = 32;
    localparam int QUOT_BITS       = 64;
    localparam int SUM_SCALE_BITS  = 14;   // 2^14 = (2^8 / 2)^2 for Q24.8 of |N|/(2|det|)

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic                         command;
        logic        [SLOT_BITS-1:0]  load_index;
        logic signed [FIELD_BITS-1:0] coord_x;
        logic signed [FIELD_BITS-1:0] coord_y;
        logic signed [FIELD_BITS-1:0] coord_z;
        logic        [SLOT_BITS-1:0]  vertex_a;
        logic        [SLOT_BITS-1:0]  vertex_b;
        logic        [SLOT_BITS-1:0]  vertex_c;
        logic        [SLOT_BITS-1:0]  vertex_d;
    } query_item_t;

    typedef struct packed {
        logic [RADIUS_BITS-1:0] radius;
        logic                   saturated;
        logic                   degenerate;
    } result_item_t;

    typedef struct packed {
        logic done;
        logic degenerate;
    } geom_status_t;

    typedef struct packed {
        logic                   done;
        logic                   saturated;
        logic [RADIUS_BITS-1:0] radius;
    } root_result_t;

    typedef enum logic [2:0] {
        TOP_IDLE,
        TOP_FETCH,
        TOP_GEOM,
        TOP_ROOT,
        TOP_HOLD
    } top_state_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_LOAD,
        ENG_RUN
    } eng_state_t;

    typedef enum logic [1:0] {
        ROOT_IDLE,
        ROOT_DIV,
        ROOT_SQRT,
        ROOT_DONE
    } root_state_t;

    // product shift in the sum accumulator, in units of the half word
    typedef enum logic [1:0] {
        SH_NONE,
        SH_HALF,
        SH_HALF_X2,
        SH_FULL
    } sh_code_t;

    // scratch map
    localparam int SCR_DEPTH     = 25;
    localparam int SCR_ADDR_BITS = 5;
    localparam int DELTA_COUNT   = 9;
    localparam logic [SCR_ADDR_BITS-1:0] SA_U0 = 5'd0,  SA_U1 = 5'd1,  SA_U2 = 5'd2;
    localparam logic [SCR_ADDR_BITS-1:0] SA_V0 = 5'd3,  SA_V1 = 5'd4,  SA_V2 = 5'd5;
    localparam logic [SCR_ADDR_BITS-1:0] SA_W0 = 5'd6,  SA_W1 = 5'd7,  SA_W2 = 5'd8;
    localparam logic [SCR_ADDR_BITS-1:0] SA_LU = 5'd9,  SA_LV = 5'd10, SA_LW = 5'd11;
    localparam logic [SCR_ADDR_BITS-1:0] SA_CVW0 = 5'd12, SA_CVW1 = 5'd13, SA_CVW2 = 5'd14;
    localparam logic [SCR_ADDR_BITS-1:0] SA_CWU0 = 5'd15, SA_CWU1 = 5'd16, SA_CWU2 = 5'd17;
    localparam logic [SCR_ADDR_BITS-1:0] SA_CUV0 = 5'd18, SA_CUV1 = 5'd19, SA_CUV2 = 5'd20;
    localparam logic [SCR_ADDR_BITS-1:0] SA_DET_LO = 5'd21, SA_DET_HI = 5'd22;
    localparam logic [SCR_ADDR_BITS-1:0] SA_N_LO = 5'd23, SA_N_HI = 5'd24;

    typedef struct packed {
        logic [SCR_ADDR_BITS-1:0] ra;
        logic [SCR_ADDR_BITS-1:0] rb;
        logic [SCR_ADDR_BITS-1:0] dst;
        logic                     neg;
        logic                     clr;
        logic                     to_sum;
        sh_code_t                 sh;
        logic                     wr;
        logic                     split;   // write lo word at dst, hi word at dst+1
        logic                     cap;     // sum accumulator -> det^2
        logic                     zchk;    // flat test on the result
        logic                     last;
    } op_t;

    localparam int OP_IDX_BITS = 6;
    localparam logic [OP_IDX_BITS-1:0] OP_END = 6'd51;

    function automatic op_t acc_op(logic [SCR_ADDR_BITS-1:0] ra, logic [SCR_ADDR_BITS-1:0] rb,
                                   logic neg, logic clr);
        op_t o;
        o        = '0;
        o.ra     = ra;
        o.rb     = rb;
        o.neg    = neg;
        o.clr    = clr;
        o.sh     = SH_NONE;
        return o;
    endfunction

    function automatic op_t wr_op(logic [SCR_ADDR_BITS-1:0] ra, logic [SCR_ADDR_BITS-1:0] rb,
                                  logic neg, logic [SCR_ADDR_BITS-1:0] dst, logic split,
                                  logic zchk);
        op_t o;
        o        = '0;
        o.ra     = ra;
        o.rb     = rb;
        o.neg    = neg;
        o.sh     = SH_NONE;
        o.wr     = 1'b1;
        o.dst    = dst;
        o.split  = split;
        o.zchk   = zchk;
        return o;
    endfunction

    function automatic op_t sq_op(logic [SCR_ADDR_BITS-1:0] ra, logic [SCR_ADDR_BITS-1:0] rb,
                                  logic clr, sh_code_t sh, logic cap, logic last);
        op_t o;
        o        = '0;
        o.ra     = ra;
        o.rb     = rb;
        o.clr    = clr;
        o.to_sum = 1'b1;
        o.sh     = sh;
        o.cap    = cap;
        o.last   = last;
        return o;
    endfunction

    // Program: |u|^2,|v|^2,|w|^2, v x w, w x u, u x v, det, det^2, then per axis
    // N_k and N_k^2 into the sum accumulator.
    function automatic op_t tcr_op(logic [OP_IDX_BITS-1:0] idx);
        op_t o;
        unique case (idx)
            6'd0:  o = acc_op(SA_U0, SA_U0, 1'b0, 1'b1);
            6'd1:  o = acc_op(SA_U1, SA_U1, 1'b0, 1'b0);
            6'd2:  o = wr_op (SA_U2, SA_U2, 1'b0, SA_LU, 1'b0, 1'b0);
            6'd3:  o = acc_op(SA_V0, SA_V0, 1'b0, 1'b1);
            6'd4:  o = acc_op(SA_V1, SA_V1, 1'b0, 1'b0);
            6'd5:  o = wr_op (SA_V2, SA_V2, 1'b0, SA_LV, 1'b0, 1'b0);
            6'd6:  o = acc_op(SA_W0, SA_W0, 1'b0, 1'b1);
            6'd7:  o = acc_op(SA_W1, SA_W1, 1'b0, 1'b0);
            6'd8:  o = wr_op (SA_W2, SA_W2, 1'b0, SA_LW, 1'b0, 1'b0);
            6'd9:  o = acc_op(SA_V1, SA_W2, 1'b0, 1'b1);
            6'd10: o = wr_op (SA_V2, SA_W1, 1'b1, SA_CVW0, 1'b0, 1'b0);
            6'd11: o = acc_op(SA_V2, SA_W0, 1'b0, 1'b1);
            6'd12: o = wr_op (SA_V0, SA_W2, 1'b1, SA_CVW1, 1'b0, 1'b0);
            6'd13: o = acc_op(SA_V0, SA_W1, 1'b0, 1'b1);
            6'd14: o = wr_op (SA_V1, SA_W0, 1'b1, SA_CVW2, 1'b0, 1'b0);
            6'd15: o = acc_op(SA_W1, SA_U2, 1'b0, 1'b1);
            6'd16: o = wr_op (SA_W2, SA_U1, 1'b1, SA_CWU0, 1'b0, 1'b0);
            6'd17: o = acc_op(SA_W2, SA_U0, 1'b0, 1'b1);
            6'd18: o = wr_op (SA_W0, SA_U2, 1'b1, SA_CWU1, 1'b0, 1'b0);
            6'd19: o = acc_op(SA_W0, SA_U1, 1'b0, 1'b1);
            6'd20: o = wr_op (SA_W1, SA_U0, 1'b1, SA_CWU2, 1'b0, 1'b0);
            6'd21: o = acc_op(SA_U1, SA_V2, 1'b0, 1'b1);
            6'd22: o = wr_op (SA_U2, SA_V1, 1'b1, SA_CUV0, 1'b0, 1'b0);
            6'd23: o = acc_op(SA_U2, SA_V0, 1'b0, 1'b1);
            6'd24: o = wr_op (SA_U0, SA_V2, 1'b1, SA_CUV1, 1'b0, 1'b0);
            6'd25: o = acc_op(SA_U0, SA_V1, 1'b0, 1'b1);
            6'd26: o = wr_op (SA_U1, SA_V0, 1'b1, SA_CUV2, 1'b0, 1'b0);
            6'd27: o = acc_op(SA_U0, SA_CVW0, 1'b0, 1'b1);
            6'd28: o = acc_op(SA_U1, SA_CVW1, 1'b0, 1'b0);
            6'd29: o = wr_op (SA_U2, SA_CVW2, 1'b0, SA_DET_LO, 1'b1, 1'b1);
            6'd30: o = sq_op (SA_DET_LO, SA_DET_LO, 1'b1, SH_NONE,    1'b0, 1'b0);
            6'd31: o = sq_op (SA_DET_HI, SA_DET_LO, 1'b0, SH_HALF_X2, 1'b0, 1'b0);
            6'd32: o = sq_op (SA_DET_HI, SA_DET_HI, 1'b0, SH_FULL,    1'b1, 1'b0);
            6'd33: o = acc_op(SA_LU, SA_CVW0, 1'b0, 1'b1);
            6'd34: o = acc_op(SA_LV, SA_CWU0, 1'b0, 1'b0);
            6'd35: o = wr_op (SA_LW, SA_CUV0, 1'b0, SA_N_LO, 1'b1, 1'b0);
            6'd36: o = sq_op (SA_N_LO, SA_N_LO, 1'b1, SH_NONE,    1'b0, 1'b0);
            6'd37: o = sq_op (SA_N_HI, SA_N_LO, 1'b0, SH_HALF_X2, 1'b0, 1'b0);
            6'd38: o = sq_op (SA_N_HI, SA_N_HI, 1'b0, SH_FULL,    1'b0, 1'b0);
            6'd39: o = acc_op(SA_LU, SA_CVW1, 1'b0, 1'b1);
            6'd40: o = acc_op(SA_LV, SA_CWU1, 1'b0, 1'b0);
            6'd41: o = wr_op (SA_LW, SA_CUV1, 1'b0, SA_N_LO, 1'b1, 1'b0);
            6'd42: o = sq_op (SA_N_LO, SA_N_LO, 1'b0, SH_NONE,    1'b0, 1'b0);
            6'd43: o = sq_op (SA_N_HI, SA_N_LO, 1'b0, SH_HALF_X2, 1'b0, 1'b0);
            6'd44: o = sq_op (SA_N_HI, SA_N_HI, 1'b0, SH_FULL,    1'b0, 1'b0);
            6'd45: o = acc_op(SA_LU, SA_CVW2, 1'b0, 1'b1);
            6'd46: o = acc_op(SA_LV, SA_CWU2, 1'b0, 1'b0);
            6'd47: o = wr_op (SA_LW, SA_CUV2, 1'b0, SA_N_LO, 1'b1, 1'b0);
            6'd48: o = sq_op (SA_N_LO, SA_N_LO, 1'b0, SH_NONE,    1'b0, 1'b0);
            6'd49: o = sq_op (SA_N_HI, SA_N_LO, 1'b0, SH_HALF_X2, 1'b0, 1'b0);
            6'd50: o = sq_op (SA_N_HI, SA_N_HI, 1'b0, SH_FULL,    1'b0, 1'b1);
            default: o = acc_op(SA_U0, SA_U0, 1'b0, 1'b0);
        endcase
        return o;
    endfunction

endpackage

[src/tcr_stream_if.sv]
// ============================================================================
// tcr_stream_if - valid/ready channel carrying one item
// An item moves on a rising edge with valid and ready both high.
// ============================================================================
interface tcr_stream_if #(
    parameter type item_t = logic
);
    logic  valid;
    logic  ready;
    item_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

[src/tcr_point_mem.sv]
// ============================================================================
// tcr_point_mem - point store
// One write port, one read port with registered read data.
// ============================================================================
module tcr_point_mem
    import tcr_pkg::*;
#(
    parameter int POINT_COUNT = POINT_COUNT_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF,
    localparam int PAW        = $clog2(POINT_COUNT)
)(
    input  logic                    clk,
    input  logic                    wr_en,
    input  logic [PAW-1:0]          wr_addr,
    input  logic [3*COORD_BITS-1:0] wr_data,
    input  logic [PAW-1:0]          rd_addr,
    output logic [3*COORD_BITS-1:0] rd_data
);

    logic [3*COORD_BITS-1:0] mem [POINT_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[src/tcr_geom_engine.sv]
// ============================================================================
// tcr_geom_engine - exact geometry on a scratch memory
// Micro-op sequencer with one signed multiplier, a main and a sum accumulator.
// Produces det^2 and |N|^2 for the root unit.
// ============================================================================
module tcr_geom_engine
    import tcr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    localparam int DIFF_BITS = COORD_BITS + 1,
    localparam int MW        = 2 * DIFF_BITS + 2,
    localparam int SUMW      = 4 * MW - 2
)(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [DIFF_BITS-1:0] deltas [DELTA_COUNT],
    output geom_status_t                status,
    output logic [SUMW-1:0]             nsum,
    output logic [SUMW-1:0]             d2
);

    localparam int HALF = MW - 1;
    localparam int ACCW = 2 * MW + 2;
    localparam logic [3:0] LD_LAST = 4'(DELTA_COUNT - 1);

    eng_state_t state_reg, state_next;
    logic       loading, running;

    logic [3:0]             ld_cnt_reg;
    logic [OP_IDX_BITS-1:0] pc_reg;
    logic [1:0]             gap_reg;
    logic                   ex_valid_reg;
    op_t                    ex_op_reg;
    logic                   hi_pend_reg;
    logic [SCR_ADDR_BITS-1:0] hi_addr_reg;
    logic                   done_reg;

    logic signed [MW-1:0]   scr_mem [SCR_DEPTH];
    logic signed [MW-1:0]   rd_a_reg, rd_b_reg;
    logic                   wr_en;
    logic [SCR_ADDR_BITS-1:0] wr_addr;
    logic signed [MW-1:0]   wr_data;

    logic signed [ACCW-1:0] acc_reg, acc_next;
    logic signed [SUMW-1:0] sacc_reg, sacc_next;
    logic [SUMW-1:0]        d2_reg;
    logic                   degen_reg;

    op_t                    cur_op;
    logic                   issue;
    logic signed [2*MW-1:0] prod;
    logic signed [ACCW-1:0] main_term;
    logic signed [SUMW-1:0] sum_term, sum_base;

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ENG_IDLE: if (start) state_next = ENG_LOAD;
            ENG_LOAD: if (ld_cnt_reg == LD_LAST) state_next = ENG_RUN;
            ENG_RUN:  if (ex_valid_reg && ex_op_reg.last) state_next = ENG_IDLE;
            default:  state_next = ENG_IDLE;
        endcase
    end

    always_comb
    begin
        loading = 1'b0;
        running = 1'b0;
        unique case (state_reg)
            ENG_LOAD: loading = 1'b1;
            ENG_RUN:  running = 1'b1;
            default:  ;
        endcase
    end

    assign cur_op = tcr_op(pc_reg);
    // issue stalls after a write, and longer after a split write: read after write hazard
    assign issue  = running && (gap_reg == 2'd0) && (pc_reg < OP_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ENG_IDLE;
            ld_cnt_reg   <= '0;
            pc_reg       <= '0;
            gap_reg      <= '0;
            ex_valid_reg <= 1'b0;
            hi_pend_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ex_valid_reg <= issue;
            hi_pend_reg  <= ex_valid_reg && ex_op_reg.wr && ex_op_reg.split;
            done_reg     <= ex_valid_reg && ex_op_reg.last;
            if (start)
            begin
                ld_cnt_reg <= '0;
                pc_reg     <= '0;
                gap_reg    <= '0;
            end
            else
            begin
                if (loading)
                begin
                    ld_cnt_reg <= ld_cnt_reg + 4'd1;
                end
                if (issue)
                begin
                    pc_reg <= pc_reg + 6'd1;
                end
                if (issue && cur_op.wr)
                begin
                    gap_reg <= cur_op.split ? 2'd2 : 2'd1;
                end
                else if (gap_reg != 2'd0)
                begin
                    gap_reg <= gap_reg - 2'd1;
                end
            end
        end
    end

    // ---------------- scratch memory ----------------
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ex_op_reg.dst;
        wr_data = acc_next[MW-1:0];
        if (loading)
        begin
            wr_en   = 1'b1;
            wr_addr = SCR_ADDR_BITS'(ld_cnt_reg);
            wr_data = MW'(deltas[ld_cnt_reg]);
        end
        else if (ex_valid_reg && ex_op_reg.wr)
        begin
            wr_en = 1'b1;
            if (ex_op_reg.split)
            begin
                wr_data = {1'b0, acc_next[HALF-1:0]};
            end
        end
        else if (hi_pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = hi_addr_reg;
            wr_data = acc_reg[HALF+MW-1:HALF];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            scr_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= scr_mem[cur_op.ra];
        rd_b_reg <= scr_mem[cur_op.rb];
    end

    // ---------------- multiply-accumulate ----------------
    assign prod      = rd_a_reg * rd_b_reg;
    assign main_term = ACCW'(prod);

    always_comb
    begin
        case (ex_op_reg.sh)
            SH_HALF:    sum_term = SUMW'(prod) <<< HALF;
            SH_HALF_X2: sum_term = SUMW'(prod) <<< (HALF + 1);
            SH_FULL:    sum_term = SUMW'(prod) <<< (2 * HALF);
            default:    sum_term = SUMW'(prod);
        endcase
        sum_base = ex_op_reg.clr ? '0 : sacc_reg;
        acc_next  = acc_reg;
        sacc_next = sacc_reg;
        if (ex_valid_reg)
        begin
            if (ex_op_reg.to_sum)
            begin
                sacc_next = sum_base + sum_term;
            end
            else if (ex_op_reg.neg)
            begin
                acc_next = (ex_op_reg.clr ? ACCW'(0) : acc_reg) - main_term;
            end
            else
            begin
                acc_next = (ex_op_reg.clr ? ACCW'(0) : acc_reg) + main_term;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ex_op_reg   <= cur_op;
        acc_reg     <= acc_next;
        sacc_reg    <= sacc_next;
        hi_addr_reg <= ex_op_reg.dst + 5'd1;
        if (ex_valid_reg && ex_op_reg.cap)
        begin
            d2_reg <= sacc_next;
        end
        if (ex_valid_reg && ex_op_reg.zchk)
        begin
            degen_reg <= (acc_next == '0);
        end
    end

    assign status.done       = done_reg;
    assign status.degenerate = degen_reg;
    assign nsum              = sacc_reg;
    assign d2                = d2_reg;

endmodule

[src/tcr_root_unit.sv]
// ============================================================================
// tcr_root_unit - quotient and square root
// Restoring division, one quotient bit a cycle, then a bit-pair square root.
// ============================================================================
module tcr_root_unit
    import tcr_pkg::*;
#(
    parameter int SUMW = 4 * (2 * (COORD_BITS_DEF + 1) + 2) - 2
)(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [SUMW-1:0] nsum,
    input  logic [SUMW-1:0] d2,
    output root_result_t    result
);

    localparam int FULLW = SUMW + SUM_SCALE_BITS;
    localparam logic [5:0] DIV_LAST  = 6'(QUOT_BITS - 1);
    localparam logic [5:0] SQRT_LAST = 6'(QUOT_BITS / 2 - 1);

    root_state_t state_reg, state_next;
    logic        dividing, rooting, done;

    logic [5:0]           cnt_reg;
    logic [SUMW-1:0]      rem_reg;
    logic [QUOT_BITS-1:0] low_reg, quot_reg, one_reg, res_reg;
    logic                 sat_reg;

    logic [FULLW-1:0]     s_full;
    logic                 sat_now;
    logic [SUMW:0]        rem_sh, rem_diff;
    logic                 ge;
    logic [QUOT_BITS-1:0] trial;
    logic                 take;

    assign s_full  = {nsum, {SUM_SCALE_BITS{1'b0}}};
    assign sat_now = SUMW'(s_full[FULLW-1:QUOT_BITS]) >= d2;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ROOT_IDLE: if (start) state_next = sat_now ? ROOT_DONE : ROOT_DIV;
            ROOT_DIV:  if (cnt_reg == DIV_LAST) state_next = ROOT_SQRT;
            ROOT_SQRT: if (cnt_reg == SQRT_LAST) state_next = ROOT_DONE;
            ROOT_DONE: state_next = ROOT_IDLE;
            default:   state_next = ROOT_IDLE;
        endcase
    end

    always_comb
    begin
        dividing = 1'b0;
        rooting  = 1'b0;
        done     = 1'b0;
        unique case (state_reg)
            ROOT_DIV:  dividing = 1'b1;
            ROOT_SQRT: rooting  = 1'b1;
            ROOT_DONE: done     = 1'b1;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ROOT_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (start || (dividing && cnt_reg == DIV_LAST))
            begin
                cnt_reg <= '0;
            end
            else if (dividing || rooting)
            begin
                cnt_reg <= cnt_reg + 6'd1;
            end
        end
    end

    assign rem_sh   = {rem_reg, low_reg[QUOT_BITS-1]};
    assign rem_diff = rem_sh - {1'b0, d2};
    assign ge       = rem_sh >= {1'b0, d2};
    assign trial    = res_reg + one_reg;
    assign take     = quot_reg >= trial;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sat_reg <= sat_now;
            rem_reg <= SUMW'(s_full[FULLW-1:QUOT_BITS]);
            low_reg <= s_full[QUOT_BITS-1:0];
            res_reg <= '0;
        end
        else if (dividing)
        begin
            rem_reg  <= ge ? rem_diff[SUMW-1:0] : rem_sh[SUMW-1:0];
            low_reg  <= {low_reg[QUOT_BITS-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_BITS-2:0], ge};
            one_reg  <= QUOT_BITS'(1) << (QUOT_BITS - 2);
            res_reg  <= '0;
        end
        else if (rooting)
        begin
            if (take)
            begin
                quot_reg <= quot_reg - trial;
                res_reg  <= (res_reg >> 1) + one_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            one_reg <= one_reg >> 2;
        end
    end

    assign result.done      = done;
    assign result.saturated = sat_reg;
    assign result.radius    = sat_reg ? '1 : res_reg[RADIUS_BITS-1:0];

endmodule

[src/tetrahedron_circumradius_unit.sv]
// ============================================================================
// tetrahedron_circumradius_unit - circumradius of four stored points
// Point store plus exact integer geometry, division and square root.
// ============================================================================
//  channel     | dir | item           | handshake
//  ------------+-----+----------------+--------------------------------
//  query_in    | in  | query_item_t   | valid/ready, load or query
//  result_out  | out | result_item_t  | valid/ready, one per query
//
// A load is written as it is accepted; the next item is taken in the cycle after.
// A query fetches four points from the one read port of the point store,
// stages the edge vectors into scratch, runs the 51 multiply-accumulate
// steps on the shared multiplier (the scratch read latency sets the
// bubbles), hands over, finds the 64 quotient bits, takes the square root
// and finishes by loading the output. A saturated quotient skips the
// division and the square root.
// Reset clears control only; the point store holds nothing defined until
// written. A stalled result waits in the output register; one more query
// may complete and wait in the root unit before input stalls.
// ============================================================================
module tetrahedron_circumradius_unit
    import tcr_pkg::*;
#(
    parameter int POINT_COUNT = POINT_COUNT_DEF,
    parameter int COORD_BITS  = COORD_BITS_DEF
)(
    input  logic       clk,
    input  logic       rst_n,
    tcr_stream_if.sink   query_in,
    tcr_stream_if.source result_out
);

    localparam int PAW       = $clog2(POINT_COUNT);
    localparam int DIFF_BITS = COORD_BITS + 1;
    localparam int MW        = 2 * DIFF_BITS + 2;
    localparam int SUMW      = 4 * MW - 2;
    localparam logic [2:0] FETCH_LAST = 3'd4;

    top_state_t state_reg, state_next;

    // handshake and control
    logic accept, load_wr, fetching, eng_start, root_start, out_load;
    query_item_t q;

    // point fetch
    logic [SLOT_BITS-1:0]    vtx_reg [4];
    logic [2:0]              fcnt_reg;
    logic [1:0]              rd_sel, pt_sel;
    logic                    rng_reg;
    logic [3*COORD_BITS-1:0] pt_reg [4];
    logic [PAW-1:0]          rd_addr;
    logic [3*COORD_BITS-1:0] rd_data;
    logic [3*COORD_BITS-1:0] wr_data;

    logic signed [DIFF_BITS-1:0] deltas [DELTA_COUNT];

    geom_status_t    geom;
    root_result_t    root;
    logic [SUMW-1:0] nsum, d2;

    logic         out_valid_reg;
    result_item_t out_data_reg;

    assign q      = query_in.data;
    assign accept = query_in.valid && query_in.ready;

    // ---------------- sequencing ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            TOP_IDLE:  if (accept && q.command == CMD_QUERY) state_next = TOP_FETCH;
            TOP_FETCH: if (fcnt_reg == FETCH_LAST) state_next = TOP_GEOM;
            TOP_GEOM:  if (geom.done) state_next = TOP_ROOT;
            TOP_ROOT:  if (root.done) state_next = TOP_HOLD;
            TOP_HOLD:  if (!out_valid_reg || result_out.ready) state_next = TOP_IDLE;
            default:   state_next = TOP_IDLE;
        endcase
    end

    always_comb
    begin
        query_in.ready = 1'b0;
        fetching       = 1'b0;
        eng_start      = 1'b0;
        root_start     = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            TOP_IDLE:  query_in.ready = 1'b1;
            TOP_FETCH:
            begin
                fetching  = 1'b1;
                eng_start = (fcnt_reg == FETCH_LAST);
            end
            TOP_GEOM:  root_start = geom.done;
            TOP_HOLD:  out_load   = !out_valid_reg || result_out.ready;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TOP_IDLE;
            fcnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fetching)
            begin
                fcnt_reg <= fcnt_reg + 3'd1;
            end
            else
            begin
                fcnt_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- point store ----------------
    // slots beyond the store are dropped on load and read as the origin
    assign load_wr = accept && q.command == CMD_LOAD && 32'(q.load_index) < POINT_COUNT;
    assign wr_data = {COORD_BITS'($unsigned(q.coord_z)),
                      COORD_BITS'($unsigned(q.coord_y)),
                      COORD_BITS'($unsigned(q.coord_x))};
    assign rd_sel  = fcnt_reg[1:0];
    assign pt_sel  = 2'(fcnt_reg - 3'd1);
    assign rd_addr = PAW'(vtx_reg[rd_sel]);

    tcr_point_mem #(
        .POINT_COUNT (POINT_COUNT),
        .COORD_BITS  (COORD_BITS)
    ) u_point_mem (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (PAW'(q.load_index)),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            vtx_reg[0] <= q.vertex_a;
            vtx_reg[1] <= q.vertex_b;
            vtx_reg[2] <= q.vertex_c;
            vtx_reg[3] <= q.vertex_d;
        end
        rng_reg <= 32'(vtx_reg[rd_sel]) < POINT_COUNT;
        if (fetching && fcnt_reg != 3'd0)
        begin
            pt_reg[pt_sel] <= rng_reg ? rd_data : '0;
        end
    end

    // edge vectors u, v, w from vertex A, x y z each
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                deltas[3*j+k] =
                    DIFF_BITS'($signed(pt_reg[j+1][k*COORD_BITS +: COORD_BITS]))
                  - DIFF_BITS'($signed(pt_reg[0][k*COORD_BITS +: COORD_BITS]));
            end
        end
    end

    // ---------------- arithmetic ----------------
    tcr_geom_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_geom_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (eng_start),
        .deltas (deltas),
        .status (geom),
        .nsum   (nsum),
        .d2     (d2)
    );

    tcr_root_unit #(
        .SUMW (SUMW)
    ) u_root_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (root_start),
        .nsum   (nsum),
        .d2     (d2),
        .result (root)
    );

    // ---------------- output register ----------------
    // a flat tetrahedron overrides whatever the root unit made of det^2 = 0
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.degenerate <= geom.degenerate;
            out_data_reg.saturated  <= geom.degenerate ? 1'b0 : root.saturated;
            out_data_reg.radius     <= geom.degenerate ? '0 : root.radius;
        end
    end

    assign result_out.valid = out_valid_reg;
    assign result_out.data  = out_data_reg;

endmodule
